// ----- rtl/core/drp_pkg.sv -----
// Shared widths, codes, handshake structs and pointer helper for the deferred release pool.
package drp_pkg;

    // Pool geometry
    localparam int POOL_DEPTH = 32;
    localparam int ADDR_W     = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

    // Field widths
    localparam int HANDLE_W   = 64;
    localparam int FRAME_W    = 32;
    localparam int FUNC_W     = 3;
    localparam int CAUSE_W    = 2;
    localparam int HOLD_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = HANDLE_W + FRAME_W;

    // Register reset values
    localparam logic [HOLD_W-1:0] HOLD_RESET  = 8'd9;
    localparam logic              DEFER_RESET = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FRAMES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFER_EN    = 1'd1;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_DEFER    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ROLLBACK = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_PAUSE    = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_RESUME   = 3'd5;

    // Release causes
    localparam logic [CAUSE_W-1:0] CAUSE_OFF     = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_EVICT   = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_EXPIRED = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_FLUSHED = 2'd3;

    typedef logic [ADDR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic set_now;
        logic set_pause;
        logic clr_pause;
        logic emit_off;
        logic append;
        logic evict;
        logic scan_step;
        logic scan_last;
        logic drain;
        logic restamp;
        logic flush;
        t_ptr rd_idx;
        t_ptr idx;
        t_cnt keep;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              handle_zero;
        logic              defer_en;
        logic              paused;
        logic              count_zero;
        logic              full;
        logic              out_free;
        logic              pend_valid;
        logic              kept;
        logic              scan_go;
        t_cnt              count;
    } t_status;

    // Advance a ring pointer by an offset below the pool depth
    function automatic t_ptr ptr_add(input t_ptr base, input t_ptr off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (ADDR_W + 1)'(POOL_DEPTH)) begin
            sum = sum - (ADDR_W + 1)'(POOL_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ----- rtl/core/drp_ram.sv -----
// Generic single write port RAM with one registered read port.
module drp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/drp_dpath.sv -----
// Datapath: input register, ring storage, age compare, pending result and output register.
module drp_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  drp_pkg::t_cmd                    i_cmd,
    output drp_pkg::t_status                 o_status,
    input  logic [drp_pkg::FUNC_W-1:0]       i_func,
    input  logic [drp_pkg::IN_DATA_W-1:0]    i_data,
    input  logic                             i_cfg_we,
    input  logic [drp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [drp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [drp_pkg::HANDLE_W-1:0]     o_out_handle,
    output logic [drp_pkg::CAUSE_W-1:0]      o_out_cause,
    output logic                             o_out_last
);

    // Configuration and control state
    logic [drp_pkg::HOLD_W-1:0]   r_hold;
    logic                         r_defer_en;
    logic                         r_paused;
    logic [drp_pkg::FRAME_W-1:0]  r_now;
    drp_pkg::t_ptr                r_head;
    drp_pkg::t_cnt                r_count;

    // Latched input transaction
    logic [drp_pkg::FUNC_W-1:0]   r_in_func;
    logic [drp_pkg::HANDLE_W-1:0] r_in_handle;
    logic [drp_pkg::FRAME_W-1:0]  r_in_frame;

    // Pending result and output register
    logic                         r_pend_valid;
    logic [drp_pkg::HANDLE_W-1:0] r_pend_handle;
    logic [drp_pkg::CAUSE_W-1:0]  r_pend_cause;
    logic                         r_out_valid;
    logic [drp_pkg::HANDLE_W-1:0] r_out_handle;
    logic [drp_pkg::CAUSE_W-1:0]  r_out_cause;
    logic                         r_out_last;

    // RAM ports
    logic                         h_we;
    drp_pkg::t_ptr                h_waddr;
    logic [drp_pkg::HANDLE_W-1:0] h_wdata;
    logic [drp_pkg::HANDLE_W-1:0] h_rdata;
    logic                         s_we;
    drp_pkg::t_ptr                s_waddr;
    logic [drp_pkg::FRAME_W-1:0]  s_rdata;
    drp_pkg::t_ptr                rd_addr;

    logic [drp_pkg::FRAME_W-1:0]  age;
    logic                         expired;
    logic                         out_free;
    logic                         out_push;
    logic [drp_pkg::HANDLE_W-1:0] out_handle;
    logic [drp_pkg::CAUSE_W-1:0]  out_cause;
    logic                         out_last;

    drp_ram #(
        .WIDTH (drp_pkg::HANDLE_W),
        .DEPTH (drp_pkg::POOL_DEPTH)
    ) u_handle_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (rd_addr),
        .o_rdata (h_rdata)
    );

    drp_ram #(
        .WIDTH (drp_pkg::FRAME_W),
        .DEPTH (drp_pkg::POOL_DEPTH)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata ((i_cmd.scan_step) ? s_rdata : r_now),
        .i_raddr (rd_addr),
        .o_rdata (s_rdata)
    );

    // Age test: outside a flush a negative signed age never expires; a flush expires every entry
    assign age      = r_now - s_rdata;
    assign expired  = i_cmd.flush ||
                      (!age[drp_pkg::FRAME_W-1] &&
                       (age > drp_pkg::FRAME_W'(r_hold)));
    assign out_free = !r_out_valid || i_out_ready;
    assign rd_addr  = drp_pkg::ptr_add(r_head, i_cmd.rd_idx);

    // Steer the RAM write ports
    always_comb begin
        h_we    = 1'b0;
        h_waddr = r_head;
        h_wdata = r_in_handle;
        s_we    = 1'b0;
        s_waddr = r_head;
        if (i_cmd.append) begin
            h_we    = 1'b1;
            s_we    = 1'b1;
            h_waddr = drp_pkg::ptr_add(r_head, r_count[drp_pkg::ADDR_W-1:0]);
            s_waddr = h_waddr;
        end else if (i_cmd.evict) begin
            h_we = 1'b1;
            s_we = 1'b1;
        end else if (i_cmd.scan_step && !expired) begin
            h_we    = 1'b1;
            s_we    = 1'b1;
            h_waddr = drp_pkg::ptr_add(r_head, i_cmd.keep[drp_pkg::ADDR_W-1:0]);
            s_waddr = h_waddr;
            h_wdata = h_rdata;
        end else if (i_cmd.restamp) begin
            s_we    = 1'b1;
            s_waddr = drp_pkg::ptr_add(r_head, i_cmd.idx);
        end
    end

    // Select what enters the output register
    always_comb begin
        out_push   = 1'b0;
        out_handle = r_pend_handle;
        out_cause  = r_pend_cause;
        out_last   = 1'b0;
        if (i_cmd.emit_off) begin
            out_push   = 1'b1;
            out_handle = r_in_handle;
            out_cause  = drp_pkg::CAUSE_OFF;
            out_last   = 1'b1;
        end else if (i_cmd.evict) begin
            out_push   = 1'b1;
            out_handle = h_rdata;
            out_cause  = drp_pkg::CAUSE_EVICT;
            out_last   = 1'b1;
        end else if (i_cmd.scan_step && expired && r_pend_valid) begin
            out_push = 1'b1;
        end else if (i_cmd.drain) begin
            out_push = 1'b1;
            out_last = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold       <= drp_pkg::HOLD_RESET;
            r_defer_en   <= drp_pkg::DEFER_RESET;
            r_paused     <= 1'b0;
            r_now        <= '0;
            r_head       <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    drp_pkg::CFG_HOLD_FRAMES: r_hold     <= i_cfg_data[drp_pkg::HOLD_W-1:0];
                    drp_pkg::CFG_DEFER_EN:    r_defer_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.set_pause) begin
                r_paused <= 1'b1;
            end else if (i_cmd.clr_pause) begin
                r_paused <= 1'b0;
            end
            if (i_cmd.set_now) begin
                r_now <= r_in_frame;
            end
            if (i_cmd.append) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.evict) begin
                r_head <= drp_pkg::ptr_add(r_head, drp_pkg::ADDR_W'(1));
            end
            if (i_cmd.scan_step && i_cmd.scan_last) begin
                r_count <= i_cmd.keep + drp_pkg::CNT_W'(!expired);
            end
            if (i_cmd.scan_step && expired) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.drain) begin
                r_pend_valid <= 1'b0;
            end
            if (out_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_func   <= i_func;
            r_in_handle <= i_data[drp_pkg::HANDLE_W-1:0];
            r_in_frame  <= i_data[drp_pkg::IN_DATA_W-1:drp_pkg::HANDLE_W];
        end
        if (i_cmd.scan_step && expired) begin
            r_pend_handle <= h_rdata;
            r_pend_cause  <= i_cmd.flush ? drp_pkg::CAUSE_FLUSHED : drp_pkg::CAUSE_EXPIRED;
        end
        if (out_push) begin
            r_out_handle <= out_handle;
            r_out_cause  <= out_cause;
            r_out_last   <= out_last;
        end
    end

    // Report status
    always_comb begin
        o_status.func        = r_in_func;
        o_status.handle_zero = (r_in_handle == '0);
        o_status.defer_en    = r_defer_en;
        o_status.paused      = r_paused;
        o_status.count_zero  = (r_count == '0);
        o_status.full        = (r_count == drp_pkg::CNT_W'(drp_pkg::POOL_DEPTH));
        o_status.out_free    = out_free;
        o_status.pend_valid  = r_pend_valid;
        o_status.kept        = !expired;
        o_status.scan_go     = !expired || !r_pend_valid || out_free;
        o_status.count       = r_count;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_handle = r_out_handle;
    assign o_out_cause  = r_out_cause;
    assign o_out_last   = r_out_last;

endmodule

// ----- rtl/core/drp_ctrl.sv -----
// Controller: sequences each transaction and walks the pool one entry per cycle while each released result has room.
module drp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  drp_pkg::t_status i_status,
    output drp_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_EVICT    = 3'd2;
    localparam logic [2:0] ST_SCAN     = 3'd3;
    localparam logic [2:0] ST_DRAIN    = 3'd4;
    localparam logic [2:0] ST_RESTAMP  = 3'd5;

    logic [2:0]    r_state, n_state;
    drp_pkg::t_ptr r_idx, n_idx;
    drp_pkg::t_cnt r_keep, n_keep;
    logic          r_flush, n_flush;
    logic          at_last;

    assign o_in_ready = (r_state == ST_IDLE);
    assign at_last    = (drp_pkg::CNT_W'(r_idx) + 1'b1) == i_status.count;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_keep       = r_keep;
        n_flush      = r_flush;
        o_cmd        = '0;
        o_cmd.rd_idx = r_idx;
        o_cmd.idx    = r_idx;
        o_cmd.keep   = r_keep;
        o_cmd.flush  = r_flush;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                o_cmd.rd_idx = '0;
                n_idx        = '0;
                n_keep       = '0;
                case (i_status.func)
                    drp_pkg::FUNC_DEFER: begin
                        if (i_status.handle_zero) begin
                            n_state = ST_IDLE;
                        end else if (!i_status.defer_en) begin
                            if (i_status.out_free) begin
                                o_cmd.emit_off = 1'b1;
                                n_state        = ST_IDLE;
                            end
                        end else if (!i_status.full) begin
                            o_cmd.append = 1'b1;
                            n_state      = ST_IDLE;
                        end else begin
                            n_state = ST_EVICT;
                        end
                    end
                    drp_pkg::FUNC_TICK: begin
                        o_cmd.set_now = 1'b1;
                        n_flush       = 1'b0;
                        n_state       = (i_status.paused || i_status.count_zero) ?
                                        ST_IDLE : ST_SCAN;
                    end
                    drp_pkg::FUNC_ROLLBACK: begin
                        n_state = i_status.count_zero ? ST_IDLE : ST_RESTAMP;
                    end
                    drp_pkg::FUNC_FLUSH: begin
                        n_flush = 1'b1;
                        n_state = i_status.count_zero ? ST_IDLE : ST_SCAN;
                    end
                    drp_pkg::FUNC_PAUSE: begin
                        o_cmd.set_pause = 1'b1;
                        n_state         = ST_IDLE;
                    end
                    drp_pkg::FUNC_RESUME: begin
                        o_cmd.clr_pause = 1'b1;
                        n_state         = ST_IDLE;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_EVICT: begin
                // Hold the oldest entry until the output register frees up
                o_cmd.rd_idx = '0;
                if (i_status.out_free) begin
                    o_cmd.evict = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // Advance one entry when its result, if any, has room
                if (i_status.scan_go) begin
                    o_cmd.scan_step = 1'b1;
                    n_keep          = r_keep + drp_pkg::CNT_W'(i_status.kept);
                    if (at_last) begin
                        o_cmd.scan_last = 1'b1;
                        n_state         = ST_DRAIN;
                    end else begin
                        n_idx        = r_idx + 1'b1;
                        o_cmd.rd_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (!i_status.pend_valid) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.drain = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_RESTAMP: begin
                o_cmd.restamp = 1'b1;
                if (at_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_keep  <= '0;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_keep  <= n_keep;
            r_flush <= n_flush;
        end
    end

endmodule

// ----- rtl/core/deferred_release_pool_core.sv -----
// Top level of the deferred release pool: stream and configuration ports, controller, datapath.
//
// Quarantine pool of drp_pkg::POOL_DEPTH handles kept in a ring buffer in two RAMs
// (handles and frame stamps). One input transaction is taken at a time: o_s_axis_tready
// is high only while the controller is idle, though a finished result may still sit in
// the output register. Pause, resume, unused codes, zero-handle defers, defers into a
// pool with room, and ticks or flushes with nothing to walk (empty pool, or a paused
// tick) go from dispatch straight back to idle. A defer with deferral off does the same,
// and a defer into a full pool first reads the oldest entry from RAM; both also wait for
// as long as the sink holds a result in the output register. A frame tick or flush walks
// the held entries through the RAM read port, one entry per cycle while no released
// result is stalled by the sink, then drains the final result; a rollback restamps each
// held entry in turn. Each handle released by a tick or flush passes through a one-entry
// pending register so that tlast marks the final result of the transaction. The pool
// needs no clearing pass after reset.
module deferred_release_pool_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input transactions
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [drp_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,  // handle[63:0], frame_number[95:64]
    input  logic [drp_pkg::FUNC_W-1:0]       i_s_axis_tuser,  // func[2:0]
    // Released handles
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [drp_pkg::HANDLE_W-1:0]     o_m_axis_tdata,  // released_handle[63:0]
    output logic [drp_pkg::CAUSE_W-1:0]      o_m_axis_tuser,  // cause[1:0]
    output logic                             o_m_axis_tlast,
    // Configuration writes
    input  logic                             i_cfg_we,
    input  logic [drp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [drp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    drp_pkg::t_cmd    cmd;
    drp_pkg::t_status status;

    drp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    drp_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_func       (i_s_axis_tuser),
        .i_data       (i_s_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_handle (o_m_axis_tdata),
        .o_out_cause  (o_m_axis_tuser),
        .o_out_last   (o_m_axis_tlast)
    );

endmodule
